### sv/pmfe_pkg.sv
// Shared types and constants for the power meter frame evaluator.
// Used by the divider, the top level and the testbench.
`default_nettype none
package pmfe_pkg;

  localparam int REG_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF = 8;
  localparam int OUT_W         = 24;
  localparam int PF_W          = 8;
  localparam int COEFF_W       = 16;
  localparam int COEFF_FRAC    = 8;
  localparam int DIVISOR_W     = 48;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd481;

  localparam logic [7:0] STATUS_VALID    = 8'h55;
  localparam logic [7:0] STATUS_CORR     = 8'hAA;
  localparam logic [3:0] STATUS_OVF_NIB  = 4'hF;

  localparam logic [1:0] CODE_VALID   = 2'd0;
  localparam logic [1:0] CODE_OVF     = 2'd1;
  localparam logic [1:0] CODE_CORR    = 2'd2;
  localparam logic [1:0] CODE_UNKNOWN = 2'd3;

  localparam logic [1:0] CFG_VOLT_COEFF = 2'd0;
  localparam logic [1:0] CFG_POW_COEFF  = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

### sv/power_meter_frame_evaluator.sv
// Power meter frame evaluator: one decoded metering frame in, one result out.
// Input channel in_*: one item per frame (status byte and six frame registers).
// Output channel out_*: one item per frame with status code and held values.
// Configuration channel cfg_*: index 0 voltage coefficient, 1 power coefficient
// (unsigned Q8.8); always ready; write only while idle.
// A valid frame runs four divisions in sequence on one shared restoring divider
// (one quotient bit per cycle, DW = max(REG_WIDTH+FRAC_BITS, REG_WIDTH+7, 38)
// bits), with a multiply after the voltage division, another after the power
// division and one for the apparent power. An overflow frame needs one division
// and one multiply; other status bytes go straight to the output.
// The input is taken only when the sequencer is idle; the result sits in an
// output register, so the next item is accepted while it waits. If the
// receiver stalls and a second result is ready, the sequencer holds it.
// Reset clears held values to zero and both coefficients to 481 (1.88).
`default_nettype none
module power_meter_frame_evaluator #(
  parameter int REG_WIDTH = pmfe_pkg::REG_WIDTH_DEF,
  parameter int FRAC_BITS = pmfe_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // status_byte, volt_param, volt_period, curr_param, curr_period, pow_param,
  // pow_period, zero pad
  input  wire logic [((8+6*REG_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // frame_status, voltage_q8, current_centi, power_q8, pf_percent, zero pad
  output logic [87:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import pmfe_pkg::*;

  localparam int W   = REG_WIDTH;
  localparam int D0  = (W + FRAC_BITS > W + 7) ? W + FRAC_BITS : W + 7;
  localparam int DW  = (D0 > 38) ? D0 : 38;
  localparam int PW  = DW + COEFF_W;

  localparam logic [3:0] S_IDLE = 4'd0, S_DV = 4'd1, S_MV = 4'd2, S_DC = 4'd3,
                         S_DP = 4'd4, S_MP = 4'd5, S_MA = 4'd6, S_DF = 4'd7,
                         S_OUT = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  code_r, code_nxt;
  logic [7:0]  status_w;
  logic [W-1:0] vpar_r, vper_r, cpar_r, cper_r, ppar_r, pper_r;
  logic [COEFF_W-1:0] vcoef_r, pcoef_r;
  logic [OUT_W-1:0] hv_r, hv_nxt, hc_r, hc_nxt, hp_r, hp_nxt;
  logic [PF_W-1:0]  hpf_r, hpf_nxt;
  logic [DW-1:0]    ratio_r, ratio_nxt;
  logic [2*OUT_W-1:0] app_r, app_nxt;
  logic         launched_r, launched_nxt;
  logic         div_start;
  logic [DW-1:0] div_dividend, div_q;
  logic [DIVISOR_W-1:0] div_divisor;
  div_sts_t     div_sts;
  logic [PW-1:0] prod;
  logic [PW-9:0] prod_sh;
  logic [OUT_W-1:0] prod_sat, q_sat;
  logic         out_valid_r, out_valid_nxt;
  logic [87:0]  out_data_r, out_data_nxt;
  logic         in_acc, div_state;

  assign status_w  = in_tdata[7:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign div_state = (state_r == S_DV) || (state_r == S_DC) ||
                     (state_r == S_DP) || (state_r == S_DF);
  assign div_start = div_state && !launched_r;

  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      S_DV: begin
        div_dividend = DW'({vpar_r, {FRAC_BITS{1'b0}}});
        div_divisor  = DIVISOR_W'(vper_r);
      end
      S_DC: begin
        div_dividend = DW'(cpar_r) * DW'(100);
        div_divisor  = DIVISOR_W'(cper_r);
      end
      S_DP: begin
        div_dividend = DW'({ppar_r, {FRAC_BITS{1'b0}}});
        div_divisor  = DIVISOR_W'(pper_r);
      end
      S_DF: begin
        div_dividend = DW'(hp_r) * DW'(10000);
        div_divisor  = DIVISOR_W'(app_r);
      end
      default: ;
    endcase
  end

  pmfe_div #(.DW(DW), .VW(DIVISOR_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .sts      (div_sts)
  );

  // scale a ratio by the coefficient of the current phase, drop the Q8.8 fraction
  assign prod     = PW'(ratio_r) * PW'((state_r == S_MV) ? vcoef_r : pcoef_r);
  assign prod_sh  = prod[PW-1:COEFF_FRAC];
  assign prod_sat = (|prod_sh[PW-9:OUT_W]) ? {OUT_W{1'b1}} : prod_sh[OUT_W-1:0];
  assign q_sat    = (|div_q[DW-1:OUT_W]) ? {OUT_W{1'b1}} : div_q[OUT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    hv_nxt        = hv_r;
    hc_nxt        = hc_r;
    hp_nxt        = hp_r;
    hpf_nxt       = hpf_r;
    ratio_nxt     = ratio_r;
    app_nxt       = app_r;
    launched_nxt  = launched_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (div_start) launched_nxt = 1'b1;
    if (div_sts.done) launched_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (status_w[7:4] == STATUS_OVF_NIB) begin
            code_nxt  = CODE_OVF;
            state_nxt = S_DV;
          end else if (status_w == STATUS_CORR) begin
            code_nxt  = CODE_CORR;
            state_nxt = S_OUT;
          end else if (status_w == STATUS_VALID) begin
            code_nxt  = CODE_VALID;
            state_nxt = S_DV;
          end else begin
            code_nxt  = CODE_UNKNOWN;
            state_nxt = S_OUT;
          end
        end
      end
      S_DV: if (div_sts.done) begin
        ratio_nxt = div_q;
        state_nxt = S_MV;
      end
      S_MV: begin
        hv_nxt = prod_sat;
        if (code_r == CODE_OVF) begin
          hc_nxt    = '0;
          hpf_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DC;
        end
      end
      S_DC: if (div_sts.done) begin
        hc_nxt    = q_sat;
        state_nxt = S_DP;
      end
      S_DP: if (div_sts.done) begin
        ratio_nxt = div_q;
        state_nxt = S_MP;
      end
      S_MP: begin
        hp_nxt    = prod_sat;
        state_nxt = S_MA;
      end
      S_MA: begin
        app_nxt   = (2*OUT_W)'(hv_r) * (2*OUT_W)'(hc_r);
        state_nxt = S_DF;
      end
      S_DF: if (div_sts.done) begin
        hpf_nxt   = (|div_q[DW-1:PF_W]) ? {PF_W{1'b1}} : div_q[PF_W-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, hpf_r, hp_r, hc_r, hv_r, code_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= CODE_VALID;
      hv_r        <= '0;
      hc_r        <= '0;
      hp_r        <= '0;
      hpf_r       <= '0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vcoef_r     <= COEFF_RESET;
      pcoef_r     <= COEFF_RESET;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      hv_r        <= hv_nxt;
      hc_r        <= hc_nxt;
      hp_r        <= hp_nxt;
      hpf_r       <= hpf_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_index == CFG_VOLT_COEFF) vcoef_r <= cfg_data;
      if (cfg_valid && cfg_index == CFG_POW_COEFF)  pcoef_r <= cfg_data;
    end
    ratio_r    <= ratio_nxt;
    app_r      <= app_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      vpar_r <= in_tdata[8 +: W];
      vper_r <= in_tdata[8+W +: W];
      cpar_r <= in_tdata[8+2*W +: W];
      cper_r <= in_tdata[8+3*W +: W];
      ppar_r <= in_tdata[8+4*W +: W];
      pper_r <= in_tdata[8+5*W +: W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> launched_r) else $error("quotient with no division launched");
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE) else $error("item accepted but sequencer idle");
  a_out_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> !launched_r && !div_sts.busy)
    else $error("result issued with division in flight");
endmodule
`default_nettype wire

### sv/pmfe_cell.sv
// One bit slice of the divider's partial remainder: shift, subtract, commit.
// Borrow ripples from the lower neighbour; no package dependency.
`default_nettype none
module pmfe_cell (
  input  wire logic clk,
  input  wire logic clr,
  input  wire logic step,
  input  wire logic take,
  input  wire logic shift_in,
  input  wire logic dvs_bit,
  input  wire logic bin,
  output logic      rem,
  output logic      bout
);
  logic rem_r, rem_nxt, diff;

  assign diff = shift_in ^ dvs_bit ^ bin;
  assign bout = (~shift_in & dvs_bit) | (~shift_in & bin) | (dvs_bit & bin);
  assign rem  = rem_r;

  always_comb begin
    rem_nxt = rem_r;
    if (clr) begin
      rem_nxt = 1'b0;
    end else if (step) begin
      rem_nxt = take ? diff : shift_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end
endmodule
`default_nettype wire

### sv/pmfe_div.sv
// Restoring divider, one quotient bit per cycle, remainder held in a row of cells.
// Depends on pmfe_pkg and pmfe_cell.
`default_nettype none
module pmfe_div #(
  parameter int DW = 48,
  parameter int VW = 48
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [DW-1:0]   dividend,
  input  wire logic [VW-1:0]   divisor,
  output logic [DW-1:0]        quotient,
  output pmfe_pkg::div_sts_t   sts
);
  import pmfe_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dq_r, dq_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [VW:0]   rem_w;
  logic [VW+1:0] brw;
  logic          take, step, clr;

  assign step = busy_r;
  assign clr  = start;
  assign take = ~brw[VW+1];
  assign brw[0] = 1'b0;

  for (genvar i = 0; i <= VW; i++) begin : g_cell
    pmfe_cell u_cell (
      .clk      (clk),
      .clr      (clr),
      .step     (step),
      .take     (take),
      .shift_in ((i == 0) ? dq_r[DW-1] : rem_w[(i == 0) ? 0 : i-1]),
      .dvs_bit  ((i < VW) ? dvs_r[(i < VW) ? i : 0] : 1'b0),
      .bin      (brw[i]),
      .rem      (rem_w[i]),
      .bout     (brw[i+1])
    );
  end

  always_comb begin
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvs_nxt = divisor;
      if (divisor == '0) begin
        dq_nxt   = '0;
        done_nxt = 1'b1;
      end else begin
        dq_nxt   = dividend;
        cnt_nxt  = CW'(DW);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DW-2:0], take};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = dq_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider started while busy");
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider busy with zero count");
endmodule
`default_nettype wire

### tb/sv/tb_power_meter_frame_evaluator.sv
// Testbench for the power meter frame evaluator: drives metering frames and
// coefficient writes, predicts held values and checks every result item.
// Depends on pmfe_pkg and the power_meter_frame_evaluator top level.
`default_nettype none
module tb_power_meter_frame_evaluator;
  import pmfe_pkg::*;

  localparam int IN_W  = ((8 + 6 * 24 + 7) / 8) * 8;
  localparam int OUT_W_TB = 88;
  localparam int DRAIN_CYCLES = 400;

  // packed from the top bit down: pf in the highest bits, code in the lowest
  typedef struct packed {
    logic [7:0]  pf;
    logic [23:0] watts;
    logic [23:0] amps;
    logic [23:0] volts;
    logic [1:0]  code;
  } meter_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W_TB-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] volt_coeff_m, pow_coeff_m;
  logic [23:0] held_v, held_c, held_p;
  logic [7:0]  held_f;
  meter_res_t  expected_results[$];
  int          errors = 0;
  int          burst_left = 0;

  power_meter_frame_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #60000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [23:0] sat24(logic [63:0] v);
    return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic logic [23:0] scale_ratio(logic [23:0] par, logic [23:0] per,
                                              logic [15:0] coeff);
    logic [63:0] ratio;
    if (per == 0) return '0;
    ratio = ({40'd0, par} << 8) / {40'd0, per};
    return sat24((ratio * {48'd0, coeff}) >> 8);
  endfunction

  // Update the held values for one frame and queue the result.
  task automatic predict_frame(logic [7:0] st, logic [23:0] vpar, logic [23:0] vper,
                               logic [23:0] cpar, logic [23:0] cper,
                               logic [23:0] ppar, logic [23:0] pper);
    meter_res_t r;
    logic [63:0] app, q;
    if (st[7:4] == STATUS_OVF_NIB) begin
      r.code = CODE_OVF;
      held_v = scale_ratio(vpar, vper, volt_coeff_m);
      held_c = '0;
      held_f = '0;
    end else if (st == STATUS_CORR) begin
      r.code = CODE_CORR;
    end else if (st == STATUS_VALID) begin
      r.code = CODE_VALID;
      held_v = scale_ratio(vpar, vper, volt_coeff_m);
      held_c = (cper == 0) ? 24'd0 : sat24(({40'd0, cpar} * 100) / {40'd0, cper});
      held_p = scale_ratio(ppar, pper, pow_coeff_m);
      app = {40'd0, held_v} * {40'd0, held_c};
      if (app == 0) held_f = '0;
      else begin
        q = ({40'd0, held_p} * 10000) / app;
        held_f = (q > 255) ? 8'd255 : q[7:0];
      end
    end else begin
      r.code = CODE_UNKNOWN;
    end
    r.volts = held_v;
    r.amps  = held_c;
    r.watts = held_p;
    r.pf    = held_f;
    expected_results.push_back(r);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Send one frame, with bursts and random gaps; valid stays high inside a burst.
  task automatic send_frame(logic [7:0] st, logic [23:0] vpar, logic [23:0] vper,
                            logic [23:0] cpar, logic [23:0] cper,
                            logic [23:0] ppar, logic [23:0] pper);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {pper, ppar, cper, cpar, vper, vpar, st};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_frame(st, vpar, vper, cpar, cper, ppar, pper);
  endtask

  task automatic wait_idle;
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coeff(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_VOLT_COEFF) volt_coeff_m = val;
    else if (idx == CFG_POW_COEFF) pow_coeff_m = val;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_reg();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 255));
      3: return 24'($urandom_range(1, 65535));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] rand_status();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return STATUS_VALID;
      5: return STATUS_CORR;
      6, 7: return {STATUS_OVF_NIB, 4'($urandom())};
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic test_directed;
    send_frame(STATUS_VALID, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    send_frame(STATUS_VALID, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'd1);
    send_frame(STATUS_VALID, 24'd230000, 24'd1000, 24'd5, 24'd1, 24'd10, 24'd1);
    send_frame(STATUS_VALID, 24'd1000, 24'd1000, 24'd1, 24'd100, 24'hFFFFFF, 24'd1);
    send_frame(STATUS_VALID, 24'd5000, 24'd40, 24'd700, 24'd9, 24'd9000, 24'd33);
    send_frame(STATUS_CORR, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'd1, 24'd1, 24'd1);
    send_frame(8'hF0, 24'd300, 24'd7, 24'd1, 24'd1, 24'd1, 24'd1);
    send_frame(8'hFF, 24'hFFFFFF, 24'd0, 24'd1, 24'd1, 24'd1, 24'd1);
    send_frame(8'h00, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
    send_frame(8'hEF, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
    send_frame(STATUS_VALID, 24'd1, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'd1, 24'hFFFFFF);
    send_frame(STATUS_VALID, 24'd100, 24'd1, 24'd0, 24'd0, 24'd5, 24'd1);
  endtask

  task automatic test_random(int count);
    repeat (count)
      send_frame(rand_status(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                 rand_reg(), rand_reg());
  endtask

  task automatic test_coeffs;
    write_coeff(CFG_VOLT_COEFF, 16'hFFFF);
    write_coeff(CFG_POW_COEFF, 16'h0000);
    test_random(150);
    wait_idle();
    write_coeff(CFG_VOLT_COEFF, 16'h0000);
    write_coeff(CFG_POW_COEFF, 16'hFFFF);
    test_random(150);
    wait_idle();
    write_coeff(CFG_VOLT_COEFF, 16'($urandom()));
    write_coeff(CFG_POW_COEFF, 16'($urandom()));
    // unused index: ignored
    write_coeff(2'd3, 16'h1234);
    test_random(300);
  endtask

  // Receiver: stall on its own pattern, check each result item.
  initial begin
    meter_res_t got, want;
    int mode;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        out_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
        @(posedge clk);
        if (out_tvalid && out_tready) begin
          got = out_tdata[81:0];
          if (expected_results.size() == 0) report("unexpected item", 0, 0);
          else begin
            want = expected_results.pop_front();
            if (got.code !== want.code) report("frame_status", got.code, want.code);
            if (got.volts !== want.volts) report("voltage_q8", got.volts, want.volts);
            if (got.amps !== want.amps) report("current_centi", got.amps, want.amps);
            if (got.watts !== want.watts) report("power_q8", got.watts, want.watts);
            if (got.pf !== want.pf) report("pf_percent", got.pf, want.pf);
          end
        end
      end
    end
  end

  initial begin
    volt_coeff_m = COEFF_RESET;
    pow_coeff_m  = COEFF_RESET;
    held_v = '0; held_c = '0; held_p = '0; held_f = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    // hold off until every result is back
    wait_idle();
    test_coeffs();
    test_random(250);
    wait_idle();
    if (errors == 0 && expected_results.size() == 0) $display("CHECK OK");
    else begin
      if (expected_results.size() != 0) report("items left over", 0, 0);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

### power_meter_frame_evaluator.f
sv/pmfe_pkg.sv
sv/pmfe_cell.sv
sv/pmfe_div.sv
sv/power_meter_frame_evaluator.sv
tb/sv/tb_power_meter_frame_evaluator.sv
